// ===== src/svpwm_duty_compare_generator_defines.svh =====
// Assertion macros for the space-vector PWM duty generator.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef SVPWM_DUTY_COMPARE_GENERATOR_DEFINES_SVH
`define SVPWM_DUTY_COMPARE_GENERATOR_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define SVPWM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle.
`define SVPWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/svpwm_pkg.sv =====
// Constants and small lookup functions for the space-vector PWM duty generator.
// No dependencies.
package svpwm_pkg;

    localparam int CMD_ONE        = 16384;
    localparam int HALF_SQRT3_Q16 = 56756;
    localparam longint POLY_A     = 102944;
    localparam longint POLY_B     = 42048;
    localparam longint POLY_C     = 4640;

    localparam logic [7:0] REG_PERIOD     = 8'd0;
    localparam logic [7:0] REG_DUTY_LIMIT = 8'd1;

    localparam logic [15:0] PERIOD_RESET     = 16'd1000;
    localparam logic [15:0] DUTY_LIMIT_RESET = 16'd62259;

    typedef enum logic [1:0] {
        TERM_ZERO,
        TERM_PLUS,
        TERM_MINUS
    } term_sel_t;

    // Sector (1..6) from {beta > 0, steep test, alpha > 0}.
    function automatic logic [2:0] sector_of_code(input logic [2:0] code);
        logic [2:0] s;
        case (code)
            3'd0:    s = 3'd4;
            3'd1:    s = 3'd6;
            3'd2:    s = 3'd5;
            3'd3:    s = 3'd5;
            3'd4:    s = 3'd3;
            3'd5:    s = 3'd1;
            3'd6:    s = 3'd2;
            3'd7:    s = 3'd2;
            default: s = 3'd4;
        endcase
        return s;
    endfunction

    // Sign of the sector boundary sine (0 or plus/minus sqrt3/2).
    function automatic term_sel_t sin_sel(input logic [2:0] idx);
        term_sel_t t;
        case (idx)
            3'd1, 3'd2: t = TERM_PLUS;
            3'd4, 3'd5: t = TERM_MINUS;
            default:    t = TERM_ZERO;
        endcase
        return t;
    endfunction

    // Switching pattern of a basic vector; bit 0 is phase A.
    function automatic logic [2:0] basic_vec(input logic [2:0] idx);
        logic [2:0] v;
        case (idx)
            3'd0:    v = 3'b001;
            3'd1:    v = 3'b011;
            3'd2:    v = 3'b010;
            3'd3:    v = 3'b110;
            3'd4:    v = 3'b100;
            3'd5:    v = 3'b101;
            default: v = 3'b000;
        endcase
        return v;
    endfunction

endpackage

// ===== src/svpwm_duty_compare_generator.sv =====
// Top level of the space-vector PWM duty generator: ten-stage pipeline.
// Depends on svpwm_pkg and svpwm_duty_compare_generator_defines.svh.
`include "svpwm_duty_compare_generator_defines.svh"

// Seven-segment space-vector PWM. Each item carries d/q commands (Q2.14,
// clamped to plus or minus one) and an electrical angle; each result carries
// three compare counts and the sector number (0 means sector 1). The block is
// a ten-stage pipeline: a new item may enter in every cycle unless a stall holds
// the first stage. An item is loaded into the first stage at its accepting edge
// and moves through the stage registers in order to the output register. The
// stage chain is: quarter-wave sine ROM read, Park
// products, alpha/beta sums, squares for the sector test, sector pick,
// sqrt3/2 product, dwell times, twice-duty sums, clamping and the period
// scaling. Each stage holds when the one after it is full and stalled, so
// bubbles close up and nothing is lost under back-pressure. The sine ROM
// holds one quarter wave, 2**(SINE_TABLE_BITS-2)+1 entries, read at two
// addresses (sine and cosine) per cycle with registered output. Write
// configuration (period, duty_limit) only while the pipeline is empty.
module svpwm_duty_compare_generator #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] volt_d,
    input  logic signed [15:0] volt_q,
    input  logic        [15:0] angle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic        [15:0] compare_a,
    output logic        [15:0] compare_b,
    output logic        [15:0] compare_c,
    output logic        [2:0]  sector_number,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [7:0]  cfg_index,
    input  logic        [15:0] cfg_data
);

    localparam int NS  = 10;
    localparam int QB  = SINE_TABLE_BITS - 2;
    localparam int AW  = SINE_TABLE_BITS - 1;
    localparam int QN  = (1 << QB) + 1;
    localparam int ZSH = 18 - SINE_TABLE_BITS;

    typedef logic [16:0] rom_t [QN];

    // Quarter-wave sine polynomial, worked out at elaboration.
    function automatic rom_t rom_fill();
        rom_t   t;
        longint z;
        longint z2;
        longint tt;
        for (int j = 0; j < QN; j++) begin
            z     = longint'(j) << ZSH;
            z2    = (z * z) >> 16;
            tt    = svpwm_pkg::POLY_B - ((z2 * svpwm_pkg::POLY_C) >> 16);
            tt    = svpwm_pkg::POLY_A - ((z2 * tt) >> 16);
            t[j]  = 17'((z * tt) >> 16);
        end
        return t;
    endfunction

    localparam rom_t SINE_ROM = rom_fill();

    // ---------------- configuration ----------------
    logic [15:0] period_reg;
    logic [15:0] duty_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            period_reg     <= svpwm_pkg::PERIOD_RESET;
            duty_limit_reg <= svpwm_pkg::DUTY_LIMIT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                svpwm_pkg::REG_PERIOD:     period_reg     <= cfg_data;
                svpwm_pkg::REG_DUTY_LIMIT: duty_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // Stage i loads when it is empty or its contents move on.
    logic [NS:1] vld_reg;
    logic [NS:1] vld_next;
    logic [NS:1] en;

    always_comb begin
        en[NS] = !vld_reg[NS] || out_ready;
        for (int i = NS - 1; i >= 1; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next = vld_reg;
        for (int i = 1; i <= NS; i++) begin
            if (en[i]) begin
                vld_next[i] = (i == 1) ? in_valid : vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = en[1];
    assign out_valid = vld_reg[NS];

    // ---------------- stage 0: clamp, ROM addresses ----------------
    logic signed [15:0]     d_clamp;
    logic signed [15:0]     q_clamp;
    logic [SINE_TABLE_BITS-1:0] k_sin;
    logic [SINE_TABLE_BITS-1:0] k_cos;
    logic [AW-1:0]          addr_sin;
    logic [AW-1:0]          addr_cos;
    logic [AW-1:0]          quarter;

    assign quarter = AW'(1 << QB);

    always_comb begin
        if (volt_d > 16'(svpwm_pkg::CMD_ONE))
            d_clamp = 16'(svpwm_pkg::CMD_ONE);
        else if (volt_d < -16'sd16384)
            d_clamp = -16'sd16384;
        else
            d_clamp = volt_d;
        if (volt_q > 16'(svpwm_pkg::CMD_ONE))
            q_clamp = 16'(svpwm_pkg::CMD_ONE);
        else if (volt_q < -16'sd16384)
            q_clamp = -16'sd16384;
        else
            q_clamp = volt_q;
        k_sin = angle[15 -: SINE_TABLE_BITS];
        k_cos = k_sin + SINE_TABLE_BITS'(1 << QB);
        // Odd quarters run the table backwards.
        addr_sin = k_sin[QB] ? quarter - AW'(k_sin[QB-1:0]) : AW'(k_sin[QB-1:0]);
        addr_cos = k_cos[QB] ? quarter - AW'(k_cos[QB-1:0]) : AW'(k_cos[QB-1:0]);
    end

    // ---------------- stage 1: ROM read ----------------
    logic [16:0]        fs_reg;
    logic [16:0]        fc_reg;
    logic               negs_reg;
    logic               negc_reg;
    logic signed [15:0] d1_reg;
    logic signed [15:0] q1_reg;

    always_ff @(posedge clk) begin
        if (en[1]) begin
            fs_reg   <= SINE_ROM[addr_sin];
            fc_reg   <= SINE_ROM[addr_cos];
            negs_reg <= k_sin[SINE_TABLE_BITS-1];
            negc_reg <= k_cos[SINE_TABLE_BITS-1];
            d1_reg   <= d_clamp;
            q1_reg   <= q_clamp;
        end
    end

    // ---------------- stage 2: Park products ----------------
    logic signed [17:0] sin_v;
    logic signed [17:0] cos_v;
    logic signed [33:0] p_cd_reg;
    logic signed [33:0] p_sq_reg;
    logic signed [33:0] p_sd_reg;
    logic signed [33:0] p_cq_reg;

    assign sin_v = negs_reg ? -$signed({1'b0, fs_reg}) : $signed({1'b0, fs_reg});
    assign cos_v = negc_reg ? -$signed({1'b0, fc_reg}) : $signed({1'b0, fc_reg});

    always_ff @(posedge clk) begin
        if (en[2]) begin
            p_cd_reg <= cos_v * d1_reg;
            p_sq_reg <= sin_v * q1_reg;
            p_sd_reg <= sin_v * d1_reg;
            p_cq_reg <= cos_v * q1_reg;
        end
    end

    // ---------------- stage 3: alpha and beta ----------------
    // Both stay within plus or minus 2**31.
    logic signed [32:0] alpha3_reg;
    logic signed [32:0] beta3_reg;

    always_ff @(posedge clk) begin
        if (en[3]) begin
            alpha3_reg <= 33'(p_cd_reg - p_sq_reg);
            beta3_reg  <= 33'(p_sd_reg + p_cq_reg);
        end
    end

    // ---------------- stage 4: squares for the sector test ----------------
    logic [31:0]        aa;
    logic [31:0]        bb;
    logic [63:0]        aa2_reg;
    logic [63:0]        bb2_reg;
    logic signed [32:0] alpha4_reg;
    logic signed [32:0] beta4_reg;

    assign aa = alpha3_reg[32] ? 32'(-alpha3_reg) : alpha3_reg[31:0];
    assign bb = beta3_reg[32]  ? 32'(-beta3_reg)  : beta3_reg[31:0];

    always_ff @(posedge clk) begin
        if (en[4]) begin
            aa2_reg    <= aa * aa;
            bb2_reg    <= bb * bb;
            alpha4_reg <= alpha3_reg;
            beta4_reg  <= beta3_reg;
        end
    end

    // ---------------- stage 5: sector pick ----------------
    logic [64:0]        aa2x3;
    logic [2:0]         code;
    logic [2:0]         sec5_reg;
    logic signed [32:0] alpha5_reg;
    logic signed [32:0] beta5_reg;

    always_comb begin
        aa2x3   = {1'b0, aa2_reg} + {aa2_reg, 1'b0};
        code[2] = !beta4_reg[32] && (beta4_reg != '0);
        code[1] = {1'b0, bb2_reg} > aa2x3;
        code[0] = !alpha4_reg[32] && (alpha4_reg != '0);
    end

    always_ff @(posedge clk) begin
        if (en[5]) begin
            sec5_reg   <= svpwm_pkg::sector_of_code(code);
            alpha5_reg <= alpha4_reg;
            beta5_reg  <= beta4_reg;
        end
    end

    // ---------------- stage 6: sqrt3/2 times alpha ----------------
    logic signed [51:0] m6_reg;
    logic signed [32:0] beta6_reg;
    logic [2:0]         sec6_reg;

    always_ff @(posedge clk) begin
        if (en[6]) begin
            m6_reg    <= 52'(alpha5_reg * $signed(18'(svpwm_pkg::HALF_SQRT3_Q16)));
            beta6_reg <= beta5_reg;
            sec6_reg  <= sec5_reg;
        end
    end

    // ---------------- stage 7: dwell times ----------------
    function automatic logic signed [51:0] sin_term(input logic [2:0] idx,
                                                    input logic signed [51:0] m);
        logic signed [51:0] r;
        case (svpwm_pkg::sin_sel(idx))
            svpwm_pkg::TERM_PLUS:  r = m;
            svpwm_pkg::TERM_MINUS: r = -m;
            default:               r = '0;
        endcase
        return r;
    endfunction

    // Sector cosines are plus or minus one or one half: shifts only.
    function automatic logic signed [51:0] cos_term(input logic [2:0] idx,
                                                    input logic signed [32:0] b);
        logic signed [51:0] bx;
        logic signed [51:0] r;
        bx = 52'(b);
        case (idx)
            3'd0, 3'd6: r = bx <<< 16;
            3'd1, 3'd5: r = bx <<< 15;
            3'd2, 3'd4: r = -(bx <<< 15);
            3'd3:       r = -(bx <<< 16);
            default:    r = '0;
        endcase
        return r;
    endfunction

    logic [2:0]         sec_prev;
    logic signed [51:0] df7_reg;
    logic signed [51:0] ds7_reg;
    logic [2:0]         sec7_reg;

    assign sec_prev = sec6_reg - 3'd1;

    always_ff @(posedge clk) begin
        if (en[7]) begin
            df7_reg  <= sin_term(sec6_reg, m6_reg) - cos_term(sec6_reg, beta6_reg);
            ds7_reg  <= cos_term(sec_prev, beta6_reg) - sin_term(sec_prev, m6_reg);
            sec7_reg <= sec6_reg;
        end
    end

    // ---------------- stage 8: twice the duties ----------------
    // twice = 2**46 - df - ds + 2*df*first + 2*ds*second, per phase.
    logic [2:0]         vec_first;
    logic [2:0]         vec_second;
    logic signed [51:0] twice8_reg [3];
    logic [2:0]         sec8_reg;

    assign vec_first  = svpwm_pkg::basic_vec(sec7_reg - 3'd1);
    assign vec_second = svpwm_pkg::basic_vec((sec7_reg == 3'd6) ? 3'd0 : sec7_reg);

    always_ff @(posedge clk) begin
        if (en[8]) begin
            for (int ph = 0; ph < 3; ph++) begin
                twice8_reg[ph] <= (52'sd1 <<< 46)
                                + (vec_first[ph]  ? df7_reg : -df7_reg)
                                + (vec_second[ph] ? ds7_reg : -ds7_reg);
            end
            sec8_reg <= sec7_reg;
        end
    end

    // ---------------- stage 9: floor and clamp ----------------
    logic [15:0] duty9_reg [3];
    logic [2:0]  sec9_reg;

    always_ff @(posedge clk) begin
        if (en[9]) begin
            for (int ph = 0; ph < 3; ph++) begin
                if (twice8_reg[ph][51])
                    duty9_reg[ph] <= '0;
                else if (twice8_reg[ph][50:31] > {4'd0, duty_limit_reg})
                    duty9_reg[ph] <= duty_limit_reg;
                else
                    duty9_reg[ph] <= twice8_reg[ph][46:31];
            end
            sec9_reg <= sec8_reg;
        end
    end

    // ---------------- stage 10: period scaling, output register ----------------
    logic [31:0] prod_a;
    logic [31:0] prod_b;
    logic [31:0] prod_c;
    logic [15:0] cmp_a_reg;
    logic [15:0] cmp_b_reg;
    logic [15:0] cmp_c_reg;
    logic [2:0]  sector_reg;

    assign prod_a = duty9_reg[0] * period_reg;
    assign prod_b = duty9_reg[1] * period_reg;
    assign prod_c = duty9_reg[2] * period_reg;

    always_ff @(posedge clk) begin
        if (en[10]) begin
            cmp_a_reg  <= prod_a[31:16];
            cmp_b_reg  <= prod_b[31:16];
            cmp_c_reg  <= prod_c[31:16];
            sector_reg <= sec9_reg - 3'd1;
        end
    end

    assign compare_a     = cmp_a_reg;
    assign compare_b     = cmp_b_reg;
    assign compare_c     = cmp_c_reg;
    assign sector_number = sector_reg;

    // ---------------- assertions ----------------
    `SVPWM_ASSERT_SAME(a_sector_range, out_valid, sector_number <= 3'd5,
        "sector number out of range")
    `SVPWM_ASSERT_SAME(a_ready_when_drained, !out_valid, in_ready,
        "input stalled with empty output register")
    `SVPWM_ASSERT_NEXT(a_hold_on_stall, vld_reg[NS] && !out_ready && vld_reg[NS-1],
        vld_reg[NS-1], "item dropped from penultimate stage during stall")
    `SVPWM_ASSERT_SAME(a_duty_clamped, vld_reg[9],
        duty9_reg[0] <= duty_limit_reg && duty9_reg[1] <= duty_limit_reg
        && duty9_reg[2] <= duty_limit_reg, "duty above limit")

endmodule
